// ----- rtl/core/lstu_pkg.sv -----
package lstu_pkg;

  // Fixed payload widths
  localparam int DATA_W    = 64;
  localparam int INSN_W    = 32;
  localparam int ADDR_W    = 21;
  localparam int REG_IDX_W = 5;
  localparam int BYTE_W    = 8;

  // Byte memory geometry
  localparam int MEM_ADDR_BITS_DEF = 21;
  localparam int NUM_BANKS         = 8;
  localparam int BANK_SEL_W        = 3;

  // Transaction opcodes
  localparam logic OPC_EXEC    = 1'b0;
  localparam logic OPC_PRELOAD = 1'b1;

  // Instruction bit positions
  localparam int BIT_SDT = 31;
  localparam int BIT_SF  = 30;
  localparam int BIT_U   = 24;
  localparam int BIT_L   = 22;
  localparam int BIT_PRE = 11;

  // Decoded kind of a transaction
  typedef enum logic [1:0] {
    KIND_PRELOAD = 2'd0,
    KIND_LOAD    = 2'd1,
    KIND_STORE   = 2'd2
  } kind_t;

endpackage

// ----- rtl/core/lstu_if.sv -----
interface lstu_in_if import lstu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [INSN_W-1:0]    instruction;
  logic [DATA_W-1:0]    base_value;
  logic [DATA_W-1:0]    store_value;
  logic [ADDR_W-1:0]    pc_value;
  logic [ADDR_W-1:0]    preload_addr;
  logic [BYTE_W-1:0]    preload_byte;

  modport source (
    output valid, opcode, instruction, base_value, store_value,
           pc_value, preload_addr, preload_byte,
    input  ready
  );
  modport sink (
    input  valid, opcode, instruction, base_value, store_value,
           pc_value, preload_addr, preload_byte,
    output ready
  );
endinterface

interface lstu_out_if import lstu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DATA_W-1:0]    load_data;
  logic                 rt_write;
  logic [REG_IDX_W-1:0] rt_index;
  logic                 base_write;
  logic [DATA_W-1:0]    base_new;
  logic [REG_IDX_W-1:0] xn_index;
  logic [ADDR_W-1:0]    access_addr;

  modport source (
    output valid, load_data, rt_write, rt_index, base_write, base_new,
           xn_index, access_addr,
    input  ready
  );
  modport sink (
    input  valid, load_data, rt_write, rt_index, base_write, base_new,
           xn_index, access_addr,
    output ready
  );
endinterface

// ----- rtl/core/lstu_byte_bank.sv -----
module lstu_byte_bank #(
  parameter int ROW_W = 18
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [ROW_W-1:0] addr,
  input  logic [7:0]       wdata,
  output logic [7:0]       rdata
);

  logic [7:0] mem [2**ROW_W];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/core/load_store_transfer_unit_top.sv -----
// Load/store transfer unit: runs A64 LDR/STR (unsigned offset, pre/post
// index, load literal) against an internal little-endian byte memory.
// in_ch carries one transaction: either an instruction with its base, store
// and PC operands, or a preload of one memory byte. out_ch returns exactly
// one result transaction per input: load data, Rt/Xn indexes, base
// write-back and the wrapped access address.
// The memory is split into eight byte-wide banks, one per lane, so any
// unaligned 4- or 8-byte access touches each bank at most once and is
// served by one access to each bank it uses. An item is decoded and its
// address formed at accept, then the banks are accessed in ST_EXEC; the
// result moves into the output register once it is free, and the next
// item can be taken in that same cycle. A new item is taken only in
// ST_IDLE, after the bank access of the last, as the banks are single-port.
// After reset the block sweeps all rows to zero, one row per cycle, with
// in_ch.ready low throughout.
// When the receiver stalls, the result holds in the output register and at
// most one further item is taken and parked until the register frees.
module load_store_transfer_unit_top import lstu_pkg::*; #(
  parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  lstu_in_if.sink        in_ch,
  lstu_out_if.source     out_ch
);

  localparam int AW    = MEM_ADDR_BITS;
  localparam int ROW_W = AW - BANK_SEL_W;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [ROW_W-1:0]     clr_cnt_r;
  logic                 resp_pend_r;

  // Request registers
  kind_t                kind_r;
  logic [AW-1:0]        addr_r;
  logic                 sf_r;
  logic [DATA_W-1:0]    data_r;
  logic [REG_IDX_W-1:0] rt_idx_r;
  logic [REG_IDX_W-1:0] xn_idx_r;
  logic                 bw_r;
  logic [DATA_W-1:0]    bnew_r;

  // Output registers
  logic                 out_valid_r;
  logic [DATA_W-1:0]    out_load_r;
  logic                 out_rtw_r;
  logic [REG_IDX_W-1:0] out_rt_r;
  logic                 out_bw_r;
  logic [DATA_W-1:0]    out_bnew_r;
  logic [REG_IDX_W-1:0] out_xn_r;
  logic [ADDR_W-1:0]    out_addr_r;

  logic in_acc, out_free, resp_move;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign resp_move    = resp_pend_r && out_free;
  assign in_ch.ready  = (state_r == ST_IDLE) && (!resp_pend_r || out_free);
  assign in_acc       = in_ch.valid && in_ch.ready;

  // Decode and address generation at accept
  logic [INSN_W-1:0] insn;
  logic              sf;
  logic [14:0]       uoff;
  logic [DATA_W-1:0] simm9, lit_off, bnew, addr_u, addr_l, eff;
  kind_t             kind;

  always_comb begin
    insn    = in_ch.instruction;
    sf      = insn[BIT_SF];
    uoff    = sf ? {insn[21:10], 3'b000} : {1'b0, insn[21:10], 2'b00};
    simm9   = {{55{insn[20]}}, insn[20:12]};
    lit_off = {{43{insn[23]}}, insn[23:5], 2'b00};
    bnew    = in_ch.base_value + simm9;
    addr_u  = in_ch.base_value + DATA_W'(uoff);
    addr_l  = DATA_W'(in_ch.pc_value) + lit_off;
    if (!insn[BIT_SDT]) begin
      eff = addr_l;
    end else if (insn[BIT_U]) begin
      eff = addr_u;
    end else if (insn[BIT_PRE]) begin
      eff = bnew;
    end else begin
      eff = in_ch.base_value;
    end
    if (in_ch.opcode == OPC_PRELOAD) begin
      kind = KIND_PRELOAD;
    end else if (!insn[BIT_SDT] || insn[BIT_L]) begin
      kind = KIND_LOAD;
    end else begin
      kind = KIND_STORE;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= kind;
      sf_r   <= sf;
      if (kind == KIND_PRELOAD) begin
        addr_r   <= in_ch.preload_addr[AW-1:0];
        data_r   <= DATA_W'(in_ch.preload_byte);
        rt_idx_r <= '0;
        xn_idx_r <= '0;
        bw_r     <= 1'b0;
        bnew_r   <= '0;
      end else begin
        addr_r   <= eff[AW-1:0];
        data_r   <= sf ? in_ch.store_value : {32'd0, in_ch.store_value[31:0]};
        rt_idx_r <= insn[4:0];
        xn_idx_r <= insn[9:5];
        bw_r     <= insn[BIT_SDT] && !insn[BIT_U];
        bnew_r   <= (insn[BIT_SDT] && !insn[BIT_U]) ? bnew : '0;
      end
    end
  end

  // Control state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (&clr_cnt_r) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_acc) state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      resp_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (state_r == ST_EXEC) begin
        resp_pend_r <= 1'b1;
      end else if (resp_move) begin
        resp_pend_r <= 1'b0;
      end
    end
  end

  // Bank port steering
  logic [NUM_BANKS-1:0] bank_we, bank_re;
  logic [ROW_W-1:0]     bank_row [NUM_BANKS];
  logic [7:0]           bank_wd  [NUM_BANKS];
  logic [7:0]           bank_rd  [NUM_BANKS];
  logic [ROW_W-1:0]     row0;
  logic [2:0]           off0;

  assign row0 = addr_r[AW-1:BANK_SEL_W];
  assign off0 = addr_r[BANK_SEL_W-1:0];

  always_comb begin
    logic [2:0] bsel, lane;
    for (int b = 0; b < NUM_BANKS; b++) begin
      bsel        = 3'(b);
      lane        = bsel - off0;
      bank_we[b]  = 1'b0;
      bank_re[b]  = 1'b0;
      bank_row[b] = (bsel >= off0) ? row0 : row0 + 1'b1;
      bank_wd[b]  = data_r[{lane, 3'b000} +: 8];
      if (state_r == ST_CLEAR) begin
        bank_we[b]  = 1'b1;
        bank_row[b] = clr_cnt_r;
        bank_wd[b]  = '0;
      end else if (state_r == ST_EXEC) begin
        case (kind_r)
          KIND_PRELOAD: begin
            bank_we[b]  = (bsel == off0);
            bank_row[b] = row0;
            bank_wd[b]  = data_r[7:0];
          end
          KIND_STORE: bank_we[b] = !lane[2] || sf_r;
          KIND_LOAD:  bank_re[b] = 1'b1;
          default:    bank_we[b] = 1'b0;
        endcase
      end
    end
  end

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    lstu_byte_bank #(.ROW_W(ROW_W)) u_bank (
      .clk   (clk),
      .we    (bank_we[g]),
      .re    (bank_re[g]),
      .addr  (bank_row[g]),
      .wdata (bank_wd[g]),
      .rdata (bank_rd[g])
    );
  end

  // Reassemble load bytes in little-endian order
  logic [DATA_W-1:0] load_val;

  always_comb begin
    logic [2:0] bsel;
    load_val = '0;
    for (int i = 0; i < NUM_BANKS; i++) begin
      bsel = off0 + 3'(i);
      if (i < 4 || sf_r) begin
        load_val[i*8 +: 8] = bank_rd[bsel];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_move) begin
      out_load_r <= (kind_r == KIND_LOAD) ? load_val : '0;
      out_rtw_r  <= (kind_r == KIND_LOAD);
      out_rt_r   <= rt_idx_r;
      out_bw_r   <= bw_r;
      out_bnew_r <= bnew_r;
      out_xn_r   <= xn_idx_r;
      out_addr_r <= ADDR_W'(addr_r);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.load_data   = out_load_r;
  assign out_ch.rt_write    = out_rtw_r;
  assign out_ch.rt_index    = out_rt_r;
  assign out_ch.base_write  = out_bw_r;
  assign out_ch.base_new    = out_bnew_r;
  assign out_ch.xn_index    = out_xn_r;
  assign out_ch.access_addr = out_addr_r;

endmodule

// ----- bench/testbench.sv -----
module testbench import lstu_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 750;
  localparam int IDLE_LIMIT     = 1200000;  // covers the post-reset memory sweep
  localparam int LONG_HOLD      = 150;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_PRINTS     = 100;
  localparam int MEM_BYTES      = 1 << MEM_ADDR_BITS_DEF;
  localparam logic [ADDR_W-1:0] MEM_MASK  = ADDR_W'((64'd1 << MEM_ADDR_BITS_DEF) - 64'd1);
  localparam logic [ADDR_W-1:0] HOT_BASE  = 21'h000100;
  localparam logic [ADDR_W-1:0] TOP_ADDR  = 21'h1FFFFF;

  typedef enum logic [1:0] {
    MODE_UOFF,
    MODE_PRE,
    MODE_POST,
    MODE_LITERAL
  } xfer_mode_t;

  typedef struct packed {
    logic                 opcode;
    logic [INSN_W-1:0]    instruction;
    logic [DATA_W-1:0]    base_value;
    logic [DATA_W-1:0]    store_value;
    logic [ADDR_W-1:0]    pc_value;
    logic [ADDR_W-1:0]    preload_addr;
    logic [BYTE_W-1:0]    preload_byte;
  } transfer_t;

  typedef struct packed {
    logic [DATA_W-1:0]    load_data;
    logic                 rt_write;
    logic [REG_IDX_W-1:0] rt_index;
    logic                 base_write;
    logic [DATA_W-1:0]    base_new;
    logic [REG_IDX_W-1:0] xn_index;
    logic [ADDR_W-1:0]    access_addr;
  } writeback_t;

  logic clk;
  logic rst_n;

  lstu_in_if  in_ch();
  lstu_out_if out_ch();

  load_store_transfer_unit_top #(
    .MEM_ADDR_BITS(MEM_ADDR_BITS_DEF)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow of the block's byte memory; starts at zero, like the block after its reset sweep
  bit [7:0] mem_model [MEM_BYTES];

  transfer_t  issue_queue[$];
  writeback_t predicted_results[$];
  transfer_t  current_item;
  writeback_t want;
  int         total_items;
  int         items_accepted;
  int         results_seen;
  int         error_count;
  int         send_gap;
  int         recv_hold;
  int         idle_cycles;
  logic       offering;

  // Execute one transaction against the shadow memory and form its writeback
  function automatic writeback_t execute_transfer(transfer_t it);
    writeback_t r;
    logic [DATA_W-1:0] ea;
    logic [DATA_W-1:0] updated_base;
    logic [INSN_W-1:0] w;
    logic [ADDR_W-1:0] lane_addr;
    int nbytes;
    r = '0;
    if (it.opcode == OPC_PRELOAD) begin
      mem_model[it.preload_addr & MEM_MASK] = it.preload_byte;
      r.access_addr = it.preload_addr & MEM_MASK;
      return r;
    end
    w = it.instruction;
    nbytes = w[BIT_SF] ? 8 : 4;
    r.rt_index = w[4:0];
    r.xn_index = w[9:5];
    if (w[BIT_SDT]) begin
      if (w[BIT_U]) begin
        ea = it.base_value + (DATA_W'(w[21:10]) << (w[BIT_SF] ? 3 : 2));
      end else begin
        updated_base = it.base_value + {{(DATA_W-9){w[20]}}, w[20:12]};
        r.base_write = 1'b1;
        r.base_new = updated_base;
        ea = w[BIT_PRE] ? updated_base : it.base_value;
      end
      r.rt_write = w[BIT_L];
    end else begin
      // load literal ignores the L bit
      ea = DATA_W'(it.pc_value) + {{(DATA_W-21){w[23]}}, w[23:5], 2'b00};
      r.rt_write = 1'b1;
    end
    r.access_addr = ea[ADDR_W-1:0] & MEM_MASK;
    // each lane wraps on its own
    for (int lane = 0; lane < nbytes; lane++) begin
      lane_addr = ADDR_W'(r.access_addr + lane) & MEM_MASK;
      if (r.rt_write) r.load_data[8*lane +: 8] = mem_model[lane_addr];
      else mem_model[lane_addr] = it.store_value[8*lane +: 8];
    end
    return r;
  endfunction

  function automatic transfer_t make_preload(logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
    transfer_t it;
    it.opcode       = OPC_PRELOAD;
    it.instruction  = $urandom();
    it.base_value   = {$urandom(), $urandom()};
    it.store_value  = {$urandom(), $urandom()};
    it.pc_value     = ADDR_W'($urandom());
    it.preload_addr = addr;
    it.preload_byte = data;
    return it;
  endfunction

  // Build an instruction whose effective address lands on target; the
  // offset field goes into imm12, simm9 or simm19 depending on mode
  function automatic transfer_t make_transfer(xfer_mode_t mode, bit is_load, bit sf,
                                              logic [ADDR_W-1:0] target, logic [18:0] offs);
    transfer_t it;
    logic [ADDR_W-1:0] span;
    it = make_preload(ADDR_W'($urandom()), BYTE_W'($urandom()));
    it.opcode = OPC_EXEC;
    it.instruction[BIT_SDT] = (mode != MODE_LITERAL);
    it.instruction[BIT_SF]  = sf;
    it.instruction[BIT_L]   = is_load;
    case (mode)
      MODE_UOFF: begin
        it.instruction[BIT_U] = 1'b1;
        it.instruction[21:10] = offs[11:0];
        span = ADDR_W'(offs[11:0]) << (sf ? 3 : 2);
        it.base_value[ADDR_W-1:0] = target - span;
      end
      MODE_PRE: begin
        it.instruction[BIT_U]   = 1'b0;
        it.instruction[BIT_PRE] = 1'b1;
        it.instruction[20:12]   = offs[8:0];
        it.base_value[ADDR_W-1:0] = target - {{(ADDR_W-9){offs[8]}}, offs[8:0]};
      end
      MODE_POST: begin
        it.instruction[BIT_U]   = 1'b0;
        it.instruction[BIT_PRE] = 1'b0;
        it.instruction[20:12]   = offs[8:0];
        it.base_value[ADDR_W-1:0] = target;
      end
      default: begin
        // simm19 overlaps the L bit
        it.instruction[23:5] = offs;
        it.pc_value = target - {offs, 2'b00};
      end
    endcase
    return it;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return HOT_BASE + ADDR_W'($urandom_range(0, 63));
    else if (sel < 85) return ADDR_W'(32'h1FFFF8 + $urandom_range(0, 15));
    else return ADDR_W'($urandom());
  endfunction

  function automatic logic [18:0] pick_offset(xfer_mode_t mode);
    if (mode == MODE_UOFF && $urandom_range(0, 1) == 0) return 19'($urandom_range(0, 7));
    return 19'($urandom());
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] exp_val);
    if (error_count < MAX_PRINTS)
      $display("MISMATCH %s: got %h, expected %h (result %0d)", what, got, exp_val, results_seen);
    error_count++;
  endtask

  // Clock and initial input values
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OPC_EXEC;
    in_ch.instruction = '0;
    in_ch.base_value = '0;
    in_ch.store_value = '0;
    in_ch.pc_value = '0;
    in_ch.preload_addr = '0;
    in_ch.preload_byte = '0;
    out_ch.ready = 1'b0;
    forever #1 clk = ~clk;
  end

  // Driver: presents queued transactions with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      offering = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        predicted_results.push_back(execute_transfer(current_item));
        items_accepted++;
        offering = 1'b0;
        send_gap = ((items_accepted / 50) % 4 == 3) ? 0 : $urandom_range(0, 12);
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (issue_queue.size() != 0) begin
          current_item = issue_queue.pop_front();
          in_ch.opcode       <= current_item.opcode;
          in_ch.instruction  <= current_item.instruction;
          in_ch.base_value   <= current_item.base_value;
          in_ch.store_value  <= current_item.store_value;
          in_ch.pc_value     <= current_item.pc_value;
          in_ch.preload_addr <= current_item.preload_addr;
          in_ch.preload_byte <= current_item.preload_byte;
          in_ch.valid        <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction, stalls the output at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected result, access_addr", out_ch.access_addr, '0);
        end else begin
          want = predicted_results.pop_front();
          if (out_ch.load_data !== want.load_data)
            report_mismatch("load_data", out_ch.load_data, want.load_data);
          if (out_ch.rt_write !== want.rt_write)
            report_mismatch("rt_write", out_ch.rt_write, want.rt_write);
          if (out_ch.rt_index !== want.rt_index)
            report_mismatch("rt_index", out_ch.rt_index, want.rt_index);
          if (out_ch.base_write !== want.base_write)
            report_mismatch("base_write", out_ch.base_write, want.base_write);
          if (out_ch.base_new !== want.base_new)
            report_mismatch("base_new", out_ch.base_new, want.base_new);
          if (out_ch.xn_index !== want.xn_index)
            report_mismatch("xn_index", out_ch.xn_index, want.xn_index);
          if (out_ch.access_addr !== want.access_addr)
            report_mismatch("access_addr", out_ch.access_addr, want.access_addr);
        end
        results_seen++;
        // long hold-off now and then so the block backs up into its input
        if (results_seen % 250 == 0) recv_hold = LONG_HOLD;
        else if ((results_seen / 50) % 4 == 1) recv_hold = 0;
        else recv_hold = $urandom_range(0, 12);
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run
  initial begin
    transfer_t  it;
    xfer_mode_t mode;
    int         sel;
    logic [18:0] offs;

    // directed: address extremes, wrap at the top of memory, every mode
    issue_queue.push_back(make_preload(TOP_ADDR, 8'hA5));
    issue_queue.push_back(make_preload('0, 8'h5A));
    issue_queue.push_back(make_preload(HOT_BASE + ADDR_W'(1), 8'hFF));
    it = make_preload(HOT_BASE + ADDR_W'(2), 8'h00);
    it.instruction = '1;
    issue_queue.push_back(it);
    issue_queue.push_back(make_transfer(MODE_UOFF, 1, 1, 21'h1FFFFC, 19'd0));
    it = make_transfer(MODE_UOFF, 0, 1, 21'h1FFFFA, 19'h00FFF);
    it.store_value = '1;
    issue_queue.push_back(it);
    issue_queue.push_back(make_transfer(MODE_UOFF, 1, 0, 21'h1FFFFE, 19'h00FFF));
    it = make_transfer(MODE_PRE, 0, 0, HOT_BASE, 19'h00100);
    it.store_value = 64'h0123456789ABCDEF;
    issue_queue.push_back(it);
    it = make_transfer(MODE_POST, 1, 1, HOT_BASE, 19'h000FF);
    it.instruction[10] = 1'b1;
    issue_queue.push_back(it);
    it = make_transfer(MODE_PRE, 1, 1, HOT_BASE, 19'd0);
    it.instruction[10] = 1'b0;
    issue_queue.push_back(it);
    it = make_transfer(MODE_POST, 0, 1, HOT_BASE + ADDR_W'(4), 19'h001FF);
    it.store_value = '0;
    issue_queue.push_back(it);
    // literal loads: store bit set and clear, offset extremes, pc extremes
    issue_queue.push_back(make_transfer(MODE_LITERAL, 1, 1, HOT_BASE, 19'h3FFFF));
    issue_queue.push_back(make_transfer(MODE_LITERAL, 0, 0, HOT_BASE, 19'h40000));
    issue_queue.push_back(make_transfer(MODE_LITERAL, 1, 1, TOP_ADDR, 19'd0));
    issue_queue.push_back(make_transfer(MODE_LITERAL, 1, 0, '0, 19'd0));
    // base register extremes with write-back wrapping
    it = make_transfer(MODE_PRE, 1, 1, HOT_BASE, 19'd1);
    it.base_value = '1;
    issue_queue.push_back(it);
    it = make_transfer(MODE_POST, 0, 0, HOT_BASE, 19'h1FF);
    it.base_value = '0;
    issue_queue.push_back(it);
    // unsigned offset with bit 11 set, then read back with it clear
    issue_queue.push_back(make_transfer(MODE_UOFF, 0, 1, HOT_BASE + ADDR_W'(16), 19'h00002));
    issue_queue.push_back(make_transfer(MODE_UOFF, 1, 1, HOT_BASE + ADDR_W'(16), 19'h00001));
    issue_queue.push_back(make_transfer(MODE_POST, 1, 0, HOT_BASE + ADDR_W'(16), 19'h00005));

    // random mix aimed at a few shared address windows
    repeat (RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        it = make_preload(pick_addr(), BYTE_W'($urandom()));
      end else if (sel < 55) begin
        mode = xfer_mode_t'($urandom_range(0, 2));
        offs = pick_offset(mode);
        it = make_transfer(mode, 0, 1'($urandom_range(0, 1)), pick_addr(), offs);
      end else begin
        mode = xfer_mode_t'($urandom_range(0, 3));
        offs = pick_offset(mode);
        it = make_transfer(mode, 1, 1'($urandom_range(0, 1)), pick_addr(), offs);
      end
      issue_queue.push_back(it);
    end
    total_items = issue_queue.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (items_accepted < total_items || predicted_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
